// File: rtl/lcom_pkg.sv
// Shared types, constants and arithmetic helpers for the light channel output mixer.
package lcom_pkg;

   localparam int FRAC_BITS = 16;
   localparam int FW = FRAC_BITS + 1;
   localparam int TW = 16;
   localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
   localparam logic [2*FW-1:0] PROD_HALF = (2*FW)'(1) << (FRAC_BITS - 1);

   // divider: quotient bits retired per stage, padded quotient width
   localparam int DIV_STEP = 4;
   localparam int DIV_STAGES = (FW + DIV_STEP - 1) / DIV_STEP;
   localparam int QP = DIV_STAGES * DIV_STEP;
   localparam int NW = TW + QP;

   localparam int CSR_AW = 4;
   localparam logic [1:0] CSR_COLD_END = 2'd0;
   localparam logic [1:0] CSR_WARM_END = 2'd1;
   localparam logic [1:0] CSR_SCALE_SRC = 2'd2;

   typedef enum logic [1:0] {
      SHARE_COLD   = 2'd0,
      SHARE_WARM   = 2'd1,
      SHARE_DIVIDE = 2'd2
   } share_kind_type;

   typedef struct packed {
      logic [FW-1:0] on_level;
      logic [FW-1:0] bright_level;
      logic [FW-1:0] red_in;
      logic [FW-1:0] green_in;
      logic [FW-1:0] blue_in;
      logic [FW-1:0] white_in;
      logic [TW-1:0] temp_in;
   } req_type;

   typedef struct packed {
      logic [FW-1:0] red_out;
      logic [FW-1:0] green_out;
      logic [FW-1:0] blue_out;
      logic [FW-1:0] white_out;
      logic [FW-1:0] cold_out;
      logic [FW-1:0] warm_out;
      logic [FW-1:0] level_out;
      logic          fully_on;
   } rsp_type;

   typedef struct packed {
      logic [TW-1:0] cold_end;
      logic [TW-1:0] warm_end;
      logic          scale_src;
   } cfg_type;

   typedef struct packed {
      logic [FW-1:0]  on_level;
      logic [FW-1:0]  bright;
      logic [FW-1:0]  red;
      logic [FW-1:0]  green;
      logic [FW-1:0]  blue;
      logic [FW-1:0]  white;
      logic [FW-1:0]  src;
      share_kind_type kind;
      logic           warm_small;
      logic [TW-1:0]  small_part;
      logic [TW-1:0]  big_part;
   } work_type;

   typedef struct packed {
      logic [FW-1:0]  red;
      logic [FW-1:0]  green;
      logic [FW-1:0]  blue;
      logic [FW-1:0]  lvl;
      logic [FW-1:0]  scaled;
      logic [FW-1:0]  white_drv;
      logic           on_full;
      share_kind_type kind;
      logic           warm_small;
      logic [TW-1:0]  big_part;
      logic [TW:0]    rem;
      logic [QP-1:0]  num;
      logic [QP-1:0]  quot;
   } pipe_type;

   // fraction product, rounded half up
   function automatic logic [FW-1:0] fmul(input logic [FW-1:0] a, input logic [FW-1:0] b);
      logic [2*FW-1:0] p;
      begin
         p = (2*FW)'(a) * (2*FW)'(b) + PROD_HALF;
         return p[FRAC_BITS+FW-1:FRAC_BITS];
      end
   endfunction

   function automatic logic [FW-1:0] sat(input logic [FW-1:0] v);
      begin
         return (v > ONE) ? ONE : v;
      end
   endfunction

endpackage

// File: rtl/lcom_front.sv
// Front end: accepts items, saturates fractions, clamps temperature, classifies the split.
module lcom_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  lcom_pkg::req_type  req_data,
   output logic               req_stall,
   input  lcom_pkg::cfg_type  cfg,
   output logic               out_valid,
   output lcom_pkg::work_type out_item,
   input  logic               out_stall
);

   logic               vld_ff;
   logic               vld_in;
   lcom_pkg::work_type item_ff;
   lcom_pkg::work_type item_in;
   logic               take;
   logic [lcom_pkg::TW-1:0] temp;
   logic [lcom_pkg::TW-1:0] wpart;
   logic [lcom_pkg::TW-1:0] cpart;

   assign req_stall = vld_ff & out_stall;
   assign take = req_valid & ~req_stall;
   assign out_valid = vld_ff;
   assign out_item = item_ff;

   always_comb begin
      temp = req_data.temp_in;
      if (temp < cfg.cold_end) begin
         temp = cfg.cold_end;
      end else if (temp > cfg.warm_end) begin
         temp = cfg.warm_end;
      end
      wpart = temp - cfg.cold_end;
      cpart = (cfg.warm_end - cfg.cold_end) - wpart;

      item_in.on_level = lcom_pkg::sat(req_data.on_level);
      item_in.bright = lcom_pkg::sat(req_data.bright_level);
      item_in.red = lcom_pkg::sat(req_data.red_in);
      item_in.green = lcom_pkg::sat(req_data.green_in);
      item_in.blue = lcom_pkg::sat(req_data.blue_in);
      item_in.white = lcom_pkg::sat(req_data.white_in);
      item_in.src = cfg.scale_src ? item_in.bright : item_in.white;

      if (cfg.warm_end == cfg.cold_end || temp == cfg.cold_end) begin
         item_in.kind = lcom_pkg::SHARE_COLD;
      end else if (cfg.cold_end > cfg.warm_end) begin
         item_in.kind = lcom_pkg::SHARE_WARM;
      end else begin
         item_in.kind = lcom_pkg::SHARE_DIVIDE;
      end

      // the larger part gets a full share; only the smaller one is divided
      if (wpart > cpart) begin
         item_in.warm_small = 1'b0;
         item_in.small_part = cpart;
         item_in.big_part = wpart;
      end else begin
         item_in.warm_small = 1'b1;
         item_in.small_part = wpart;
         item_in.big_part = cpart;
      end
   end

   assign vld_in = take ? 1'b1 : (out_stall ? vld_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: rtl/lcom_queue.sv
// Short queue of classified items between the front and back ends.
module lcom_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  lcom_pkg::work_type in_item,
   output logic               in_stall,
   output logic               out_valid,
   output lcom_pkg::work_type out_item,
   input  logic               out_stall
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   lcom_pkg::work_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          push, pop;

   assign in_stall = (cnt_ff == CW'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_item = mem_ff[rd_ff];
   assign push = in_valid & ~in_stall;
   assign pop = out_valid & ~out_stall;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push & ~pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop & ~push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

// File: rtl/lcom_back.sv
// Back end: products, pipelined share divider and the output register.
module lcom_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  lcom_pkg::work_type in_item,
   output logic               in_stall,
   output logic               rsp_valid,
   output lcom_pkg::rsp_type  rsp_data,
   input  logic               rsp_stall
);

   localparam int NST = lcom_pkg::DIV_STAGES;

   lcom_pkg::pipe_type st_ff [NST+1];
   lcom_pkg::pipe_type st_in [NST+1];
   logic [NST:0]       vld_ff;
   logic               out_vld_ff;
   lcom_pkg::rsp_type  out_ff;
   lcom_pkg::rsp_type  out_in;
   logic               adv;
   logic [lcom_pkg::NW-1:0] numx;
   logic [lcom_pkg::FW-1:0] share_small;
   logic [lcom_pkg::FW-1:0] cold_share;
   logic [lcom_pkg::FW-1:0] warm_share;
   logic                    qbit;

   // the whole pipe moves together unless the output is held
   assign adv = ~(out_vld_ff & rsp_stall);
   assign in_stall = ~adv;
   assign rsp_valid = out_vld_ff;
   assign rsp_data = out_ff;

   always_comb begin
      numx = (lcom_pkg::NW'(in_item.small_part) << lcom_pkg::FRAC_BITS)
           + lcom_pkg::NW'(in_item.big_part >> 1);
      st_in[0].red = in_item.red;
      st_in[0].green = in_item.green;
      st_in[0].blue = in_item.blue;
      st_in[0].lvl = lcom_pkg::fmul(in_item.on_level, in_item.bright);
      st_in[0].scaled = lcom_pkg::fmul(in_item.on_level, in_item.src);
      st_in[0].white_drv = lcom_pkg::fmul(in_item.on_level, in_item.white);
      st_in[0].on_full = (in_item.on_level == lcom_pkg::ONE);
      st_in[0].kind = in_item.kind;
      st_in[0].warm_small = in_item.warm_small;
      st_in[0].big_part = in_item.big_part;
      st_in[0].rem = {1'b0, numx[lcom_pkg::NW-1:lcom_pkg::QP]};
      st_in[0].num = numx[lcom_pkg::QP-1:0];
      st_in[0].quot = '0;

      for (int k = 1; k <= NST; k++) begin
         st_in[k] = st_ff[k-1];
         if (k == 1) begin
            st_in[k].red = lcom_pkg::fmul(st_ff[0].lvl, st_ff[0].red);
            st_in[k].green = lcom_pkg::fmul(st_ff[0].lvl, st_ff[0].green);
            st_in[k].blue = lcom_pkg::fmul(st_ff[0].lvl, st_ff[0].blue);
         end
         for (int j = 0; j < lcom_pkg::DIV_STEP; j++) begin
            st_in[k].rem = {st_in[k].rem[lcom_pkg::TW-1:0], st_in[k].num[lcom_pkg::QP-1]};
            st_in[k].num = {st_in[k].num[lcom_pkg::QP-2:0], 1'b0};
            qbit = (st_in[k].rem >= {1'b0, st_in[k].big_part});
            if (qbit) begin
               st_in[k].rem = st_in[k].rem - {1'b0, st_in[k].big_part};
            end
            st_in[k].quot = {st_in[k].quot[lcom_pkg::QP-2:0], qbit};
         end
      end

      share_small = st_ff[NST].quot[lcom_pkg::FW-1:0];
      case (st_ff[NST].kind)
         lcom_pkg::SHARE_COLD: begin
            cold_share = lcom_pkg::ONE;
            warm_share = '0;
         end
         lcom_pkg::SHARE_WARM: begin
            cold_share = '0;
            warm_share = lcom_pkg::ONE;
         end
         lcom_pkg::SHARE_DIVIDE: begin
            cold_share = st_ff[NST].warm_small ? lcom_pkg::ONE : share_small;
            warm_share = st_ff[NST].warm_small ? share_small : lcom_pkg::ONE;
         end
         default: begin
            cold_share = lcom_pkg::ONE;
            warm_share = '0;
         end
      endcase

      out_in.red_out = st_ff[NST].red;
      out_in.green_out = st_ff[NST].green;
      out_in.blue_out = st_ff[NST].blue;
      out_in.white_out = st_ff[NST].white_drv;
      out_in.cold_out = lcom_pkg::fmul(st_ff[NST].scaled, cold_share);
      out_in.warm_out = lcom_pkg::fmul(st_ff[NST].scaled, warm_share);
      out_in.level_out = st_ff[NST].lvl;
      out_in.fully_on = st_ff[NST].on_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-1:0], in_valid};
         out_vld_ff <= vld_ff[NST];
      end
      if (adv) begin
         for (int k = 0; k <= NST; k++) begin
            st_ff[k] <= st_in[k];
         end
         out_ff <= out_in;
      end
   end

endmodule

// File: rtl/light_channel_output_mixer_unit.sv
// Path: an accepted item passes the front register, the queue, then six back
//   stages holding the four-bit-per-stage share divider, and the output register.
// Throughput: one item per cycle; the back pipe moves as a whole and only the
//   output register stalling on rsp_stall holds it, with the queue absorbing the front.
// Reset: synchronous, clears all valid flags, queue pointers and the registers
//   to cold end 153, warm end 500, scale by white.
module light_channel_output_mixer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  lcom_pkg::req_type           req_data,
   output logic                        req_stall,
   output logic                        rsp_valid,
   output lcom_pkg::rsp_type           rsp_data,
   input  logic                        rsp_stall,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [lcom_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   lcom_pkg::cfg_type  cfg_ff;
   lcom_pkg::cfg_type  cfg_in;
   logic               wr_en;
   logic [1:0]         reg_idx;
   logic               f_valid, f_stall, b_valid, b_stall;
   lcom_pkg::work_type f_item, b_item;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      csr_prdata = '0;
      case (reg_idx)
         lcom_pkg::CSR_COLD_END: begin
            csr_prdata = {16'd0, cfg_ff.cold_end};
            if (wr_en) cfg_in.cold_end = csr_pwdata[15:0];
         end
         lcom_pkg::CSR_WARM_END: begin
            csr_prdata = {16'd0, cfg_ff.warm_end};
            if (wr_en) cfg_in.warm_end = csr_pwdata[15:0];
         end
         lcom_pkg::CSR_SCALE_SRC: begin
            csr_prdata = {31'd0, cfg_ff.scale_src};
            if (wr_en) cfg_in.scale_src = csr_pwdata[0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cold_end <= 16'd153;
         cfg_ff.warm_end <= 16'd500;
         cfg_ff.scale_src <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcom_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_data(req_data), .req_stall(req_stall),
      .cfg(cfg_ff),
      .out_valid(f_valid), .out_item(f_item), .out_stall(f_stall)
   );

   lcom_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_item(f_item), .in_stall(f_stall),
      .out_valid(b_valid), .out_item(b_item), .out_stall(b_stall)
   );

   lcom_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(b_valid), .in_item(b_item), .in_stall(b_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall)
   );

endmodule

// File: rtl/lcom_checker.sv
// Port-level checks for the light channel output mixer, bound to the top level.
module lcom_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input lcom_pkg::rsp_type rsp_data,
   input logic              rsp_stall
);

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_req_open_after_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_color_below_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.red_out <= rsp_data.level_out
                 && rsp_data.green_out <= rsp_data.level_out
                 && rsp_data.blue_out <= rsp_data.level_out)
      else $error("color drive above level");

   a_white_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cold_out <= lcom_pkg::ONE && rsp_data.warm_out <= lcom_pkg::ONE)
      else $error("white drive above full scale");

endmodule

bind light_channel_output_mixer_unit lcom_checker u_lcom_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall)
);
